FILE: src/lcms_pkg.sv
// ----------------------------------------------------------------------------
// lcms_pkg
// Shared types, constants and the divide-by-1023 helper for the label counter
// and two-motor sequencer.
// ----------------------------------------------------------------------------
package lcms_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  localparam logic [15:0] TAIL_RESET = 16'd2000;
  localparam logic [9:0]  POT_FULL   = 10'd1023;
  localparam logic [13:0] RUN_MIN    = 14'd1000;
  localparam logic [13:0] RUN_SPAN   = 14'd9000;
  localparam logic [9:0]  LOCK_SPAN  = 10'd999;

  typedef struct packed {
    req_e        req_type;
    logic        sensor_level;
    logic [9:0]  pot_value;
  } in_t;

  typedef struct packed {
    logic [15:0] label_count;
    logic        motor_one_enable;
    logic        motor_two_enable;
    logic        motor_one_step;
    logic        motor_two_step;
  } out_t;

  // Item after the front stage: request plus derived times.
  typedef struct packed {
    logic        valid;
    req_e        req_type;
    logic        sensor_level;
    logic [9:0]  lockout_ms;
    logic [13:0] run_ms;
  } front_t;

  // floor(y / 1023) for y < 1023 * 2^14: geometric-series estimate plus one fixup.
  function automatic logic [13:0] div1023(input logic [23:0] y);
    logic [24:0] s;
    logic [13:0] q;
    logic [24:0] r;
    s = {1'b0, y} + {11'b0, y[23:10]} + {21'b0, y[23:20]};
    q = s[23:10];
    r = {1'b0, y} - {1'b0, q, 10'b0} + {11'b0, q};
    if (r >= 25'(POT_FULL)) begin
      q = q + 14'd1;
    end
    return q;
  endfunction

endpackage

FILE: src/lcms_front.sv
// ----------------------------------------------------------------------------
// lcms_front
// Input register; derives lockout and run times from the pot sample.
// ----------------------------------------------------------------------------
module lcms_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lcms_pkg::in_t  in_i,
  input  logic           next_ready_i,
  output lcms_pkg::front_t front_o
);
  import lcms_pkg::*;

  logic        valid_q, valid_d;
  front_t      item_q;
  logic [23:0] lock_prod, run_prod;
  logic [9:0]  lockout_d;
  logic [13:0] run_d;
  logic [13:0] lock_quo;

  assign in_ready_o = !valid_q || next_ready_i;

  assign lock_prod = 24'(in_i.pot_value) * 24'(LOCK_SPAN);
  assign run_prod  = 24'(in_i.pot_value) * 24'(RUN_SPAN);
  assign lock_quo  = div1023(lock_prod);
  assign lockout_d = lock_quo[9:0] + 10'd1;
  assign run_d     = div1023(run_prod) + RUN_MIN;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.valid        <= 1'b1;
      item_q.req_type     <= in_i.req_type;
      item_q.sensor_level <= in_i.sensor_level;
      item_q.lockout_ms   <= lockout_d;
      item_q.run_ms       <= run_d;
    end
  end

  always_comb begin
    front_o       = item_q;
    front_o.valid = valid_q;
  end

endmodule

FILE: src/lcms_core.sv
// ----------------------------------------------------------------------------
// lcms_core
// Counter, lockout and motor timer state; result register.
// ----------------------------------------------------------------------------
module lcms_core #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lcms_pkg::front_t front_i,
  output logic             ready_o,
  input  logic             cfg_valid_i,
  input  logic [15:0]      cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lcms_pkg::out_t   out_o
);
  import lcms_pkg::*;

  localparam int CmpW = TIME_BITS + 2;

  logic [TIME_BITS-1:0]  now_q, now_d, last_q, last_d;
  logic [TIME_BITS-1:0]  m1_start_q, m1_start_d, m2_start_q, m2_start_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  latch_q, latch_d, m1_run_q, m1_run_d, m2_run_q, m2_run_d;
  logic [15:0]           tail_q;
  logic                  out_valid_q;
  out_t                  out_q, out_d;

  logic                  fire;
  logic [TIME_BITS-1:0]  now_tick, el_last, el_m1, el_m2, m2_start_eff;
  logic                  m1_done, m2_done;
  logic [CmpW-1:0]       m2_limit;

  assign ready_o     = !out_valid_q || out_ready_i;
  assign fire        = front_i.valid && ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign now_tick     = now_q + TIME_BITS'(1);
  assign el_last      = now_tick - last_q;
  assign el_m1        = now_tick - m1_start_q;
  assign m1_done      = el_m1 >= TIME_BITS'(front_i.run_ms);
  assign m2_start_eff = (m1_run_q && m1_done) ? now_tick : m2_start_q;
  assign el_m2        = now_tick - m2_start_eff;
  assign m2_limit     = CmpW'(front_i.run_ms) + CmpW'(tail_q);
  assign m2_done      = CmpW'(el_m2) >= m2_limit;

  always_comb begin
    now_d      = now_q;
    last_d     = last_q;
    latch_d    = latch_q;
    count_d    = count_q;
    m1_run_d   = m1_run_q;
    m2_run_d   = m2_run_q;
    m1_start_d = m1_start_q;
    m2_start_d = m2_start_q;
    out_d      = '0;
    case (front_i.req_type)
      REQ_TICK: begin
        now_d = now_tick;
        if (!front_i.sensor_level && !latch_q &&
            (el_last > TIME_BITS'(front_i.lockout_ms))) begin
          count_d = count_q + COUNT_BITS'(1);
          latch_d = 1'b1;
          last_d  = now_tick;
        end else if (front_i.sensor_level) begin
          latch_d = 1'b0;
        end
        if (m1_run_q) begin
          out_d.motor_one_enable = 1'b1;
          out_d.motor_one_step   = 1'b1;
          if (m1_done) begin
            m1_run_d   = 1'b0;
            m2_start_d = now_tick;
          end
        end
        if (m2_run_q) begin
          if (m2_done) begin
            m2_run_d = 1'b0;
          end else begin
            out_d.motor_two_enable = 1'b1;
            out_d.motor_two_step   = 1'b1;
          end
        end
      end
      REQ_START: begin
        m1_run_d   = 1'b1;
        m2_run_d   = 1'b1;
        m1_start_d = now_q;
        m2_start_d = now_q;
      end
      REQ_STOP: begin
        m1_run_d = 1'b0;
        m2_run_d = 1'b0;
      end
      REQ_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
    if (front_i.req_type != REQ_TICK) begin
      out_d.motor_one_enable = m1_run_d;
      out_d.motor_two_enable = m2_run_d;
    end
    out_d.label_count = 16'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      last_q      <= '0;
      latch_q     <= 1'b0;
      count_q     <= '0;
      m1_run_q    <= 1'b0;
      m2_run_q    <= 1'b0;
      m1_start_q  <= '0;
      m2_start_q  <= '0;
      tail_q      <= TAIL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tail_q <= cfg_data_i;
      end
      if (fire) begin
        now_q      <= now_d;
        last_q     <= last_d;
        latch_q    <= latch_d;
        count_q    <= count_d;
        m1_run_q   <= m1_run_d;
        m2_run_q   <= m2_run_d;
        m1_start_q <= m1_start_d;
        m2_start_q <= m2_start_d;
      end
      if (ready_o) begin
        out_valid_q <= front_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: src/label_counter_two_motor_sequencer_top.sv
// ----------------------------------------------------------------------------
// label_counter_two_motor_sequencer_top
// Label counter with lockout and a two-motor run sequencer, one result per
// transaction.
//
// Input channel (in_valid_i/in_ready_o, in_i) carries a millisecond tick with
// sensor level and pot sample, or a start, stop or count-clear command.
// Output channel (out_valid_o/out_ready_i, out_o) returns the label count and
// motor enable/step levels for each input transaction, in order.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i) writes tail_ms; it is
// always ready and should only be written while the block is idle.
// The input register loads lockout/run times derived from the pot sample on
// acceptance; the state update then loads the result register, from which
// the result is taken when the receiver is ready.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready_o drops once both are occupied.
// Reset clears counters, timers and motor flags and sets tail_ms to 2000.
// ----------------------------------------------------------------------------
module label_counter_two_motor_sequencer_top #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lcms_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lcms_pkg::out_t out_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);
  import lcms_pkg::*;

  front_t front;
  logic   core_ready;

  assign cfg_ready_o = 1'b1;

  lcms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .next_ready_i (core_ready),
    .front_o      (front)
  );

  lcms_core #(
    .COUNT_BITS (COUNT_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .front_i     (front),
    .ready_o     (core_ready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

FILE: src/lcms_checker.sv
// ----------------------------------------------------------------------------
// lcms_checker
// Port-level assertions for the label counter and two-motor sequencer.
// ----------------------------------------------------------------------------
module lcms_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input lcms_pkg::out_t out_o
);
  import lcms_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed under stall");

  a_step_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_o.motor_one_step || out_o.motor_one_enable) &&
                    (!out_o.motor_two_step || out_o.motor_two_enable))
    else $error("step without enable");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output side free");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without matching transaction");

endmodule

bind label_counter_two_motor_sequencer_top lcms_checker u_lcms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
